>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rrts_pkg.sv
package rrts_pkg;

    localparam int THREAD_SLOTS = 16;
    localparam int SLOT_W       = $clog2(THREAD_SLOTS);
    localparam int ID_W         = 4;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int PHASE_W      = 2;

    localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_JOIN   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_EXIT   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BLOCKED   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MAIN_BUSY = 2'd3;

    localparam logic [PHASE_W-1:0] PH_FREE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_READY   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RUNNING = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     target_slot;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]     thread_id;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     running_slot;
    } result_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               exited;
        logic               blocked;
        logic               joiner_valid;
        logic [SLOT_W-1:0]  joiner;
    } slot_entry_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  addr;
        logic               phase_en;
        logic [PHASE_W-1:0] phase;
        logic               exited_en;
        logic               exited;
        logic               blocked_en;
        logic               blocked;
        logic               joiner_en;
        logic [SLOT_W-1:0]  joiner;
    } slot_write_t;

endpackage

>>> rtl/core/rrts_slot_table.sv
module rrts_slot_table
    import rrts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] rd_addr,
    output slot_entry_t       rd_entry,
    input  slot_write_t       wr
);

    logic [PHASE_W-1:0] phase_reg   [THREAD_SLOTS];
    logic               exited_reg  [THREAD_SLOTS];
    logic               blocked_reg [THREAD_SLOTS];
    logic               jvalid_reg  [THREAD_SLOTS];
    logic [SLOT_W-1:0]  joiner_reg  [THREAD_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                phase_reg[i]   <= (i == 0) ? PH_RUNNING : PH_FREE;
                exited_reg[i]  <= 1'b0;
                blocked_reg[i] <= 1'b0;
                jvalid_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            if (wr.phase_en)
            begin
                phase_reg[wr.addr] <= wr.phase;
            end
            if (wr.exited_en)
            begin
                exited_reg[wr.addr] <= wr.exited;
            end
            if (wr.blocked_en)
            begin
                blocked_reg[wr.addr] <= wr.blocked;
            end
            if (wr.joiner_en)
            begin
                jvalid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.joiner_en)
        begin
            joiner_reg[wr.addr] <= wr.joiner;
        end
    end

    always_comb
    begin
        rd_entry.phase        = phase_reg[rd_addr];
        rd_entry.exited       = exited_reg[rd_addr];
        rd_entry.blocked      = blocked_reg[rd_addr];
        rd_entry.joiner_valid = jvalid_reg[rd_addr];
        rd_entry.joiner       = joiner_reg[rd_addr];
    end

endmodule

>>> rtl/core/rrts_seq.sv
module rrts_seq
    import rrts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  item_t             item,
    output logic              idle,
    output logic [SLOT_W-1:0] rd_addr,
    input  slot_entry_t       rd_entry,
    output slot_write_t       wr,
    output logic              done,
    output result_t           res,
    input  logic              take
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN      = 4'd1;
    localparam logic [3:0] S_WR_OLD    = 4'd2;
    localparam logic [3:0] S_WR_NEW    = 4'd3;
    localparam logic [3:0] S_JOIN      = 4'd4;
    localparam logic [3:0] S_BLOCK     = 4'd5;
    localparam logic [3:0] S_EXIT      = 4'd6;
    localparam logic [3:0] S_MAIN_SCAN = 4'd7;
    localparam logic [3:0] S_FREE      = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    localparam int                CMP_W     = SLOT_W + ID_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);

    logic [3:0]          state_reg, state_next;
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [ID_W-1:0]     target_reg, target_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOT_W-1:0]   new_reg, new_next;
    logic                old_run_reg, old_run_next;
    logic [SLOT_W-1:0]   tid_reg, tid_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [SLOT_W-1:0] idx_step;
    logic [SLOT_W-1:0] target_idx;
    logic              target_ok;
    logic              scan_hit;

    assign idx_step   = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
    assign target_idx = SLOT_W'(target_reg);
    assign target_ok  = CMP_W'(target_reg) < CMP_W'(THREAD_SLOTS);
    assign scan_hit   = (action_reg == ACT_CREATE)
                      ? (!rd_entry.exited && rd_entry.phase == PH_FREE)
                      : (rd_entry.phase == PH_READY && !rd_entry.blocked);

    always_comb
    begin
        case (state_reg)
            S_JOIN:  rd_addr = target_idx;
            S_EXIT:  rd_addr = cur_reg;
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        action_next  = action_reg;
        target_next  = target_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        new_next     = new_reg;
        old_run_next = old_run_reg;
        tid_next     = tid_reg;
        status_next  = status_reg;
        wr           = '0;
        wr.addr      = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = item.action;
                    target_next = item.target_slot;
                    cnt_next    = '0;
                    status_next = STAT_DONE;
                    tid_next    = cur_reg;
                    case (item.action)
                        ACT_CREATE:
                        begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        ACT_TICK:
                        begin
                            idx_next   = cur_reg;
                            state_next = S_SCAN;
                        end
                        ACT_JOIN: state_next = S_JOIN;
                        default:  state_next = S_EXIT;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (action_reg == ACT_TICK && cnt_reg == '0)
                begin
                    old_run_next = (rd_entry.phase == PH_RUNNING);
                end
                if (scan_hit)
                begin
                    if (action_reg == ACT_CREATE)
                    begin
                        wr.addr       = idx_reg;
                        wr.phase_en   = 1'b1;
                        wr.phase      = PH_READY;
                        wr.exited_en  = 1'b1;
                        wr.exited     = 1'b0;
                        wr.blocked_en = 1'b1;
                        wr.blocked    = 1'b0;
                        tid_next      = idx_reg;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        new_next   = idx_reg;
                        state_next = S_WR_OLD;
                    end
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    if (action_reg == ACT_CREATE)
                    begin
                        tid_next    = '0;
                        status_next = STAT_NO_FREE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        new_next   = cur_reg;
                        state_next = S_WR_OLD;
                    end
                end
                else
                begin
                    idx_next = idx_step;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WR_OLD:
            begin
                wr.addr     = cur_reg;
                wr.phase_en = old_run_reg;
                wr.phase    = PH_READY;
                state_next  = S_WR_NEW;
            end
            S_WR_NEW:
            begin
                wr.addr     = new_reg;
                wr.phase_en = 1'b1;
                wr.phase    = PH_RUNNING;
                cur_next    = new_reg;
                tid_next    = new_reg;
                state_next  = S_DONE;
            end
            S_JOIN:
            begin
                if (target_ok && !rd_entry.exited)
                begin
                    wr.addr      = target_idx;
                    wr.joiner_en = 1'b1;
                    wr.joiner    = cur_reg;
                    status_next  = STAT_BLOCKED;
                    state_next   = S_BLOCK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BLOCK:
            begin
                wr.addr       = cur_reg;
                wr.blocked_en = 1'b1;
                wr.blocked    = 1'b1;
                state_next    = S_DONE;
            end
            S_EXIT:
            begin
                if (rd_entry.joiner_valid)
                begin
                    wr.addr       = rd_entry.joiner;
                    wr.blocked_en = 1'b1;
                    wr.blocked    = 1'b0;
                end
                if (cur_reg == '0)
                begin
                    idx_next   = SLOT_W'(1);
                    state_next = S_MAIN_SCAN;
                end
                else
                begin
                    state_next = S_FREE;
                end
            end
            S_MAIN_SCAN:
            begin
                if (rd_entry.phase == PH_READY)
                begin
                    status_next = STAT_MAIN_BUSY;
                    state_next  = S_DONE;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_step;
                end
            end
            S_FREE:
            begin
                wr.addr      = cur_reg;
                wr.phase_en  = 1'b1;
                wr.phase     = PH_FREE;
                wr.exited_en = 1'b1;
                wr.exited    = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        target_reg  <= target_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        new_reg     <= new_next;
        old_run_reg <= old_run_next;
        tid_reg     <= tid_next;
        status_reg  <= status_next;
    end

    assign idle             = (state_reg == S_IDLE);
    assign done             = (state_reg == S_DONE);
    assign res.thread_id    = ID_W'(tid_reg);
    assign res.status       = status_reg;
    assign res.running_slot = ID_W'(cur_reg);

endmodule

>>> rtl/core/round_robin_thread_scheduler_core.sv
// Round-robin thread scheduler over a table of THREAD_SLOTS slots (16). Each item
// is one action (create, tick, join, exit) and yields exactly one result beat with
// the affected slot, a status code and the slot running afterwards. The block takes
// one item at a time: the slot table has a single read port, and a sequencer walks
// it one slot per cycle. Create and tick scan up to THREAD_SLOTS slots before the
// result beat is formed; the next item is taken while that result waits in the
// output register.
`include "assert_macros.svh"

module round_robin_thread_scheduler_core
    import rrts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic              seq_idle;
    logic              seq_start;
    logic              seq_done;
    logic              seq_take;
    result_t           seq_res;
    logic [SLOT_W-1:0] rd_addr;
    slot_entry_t       rd_entry;
    slot_write_t       wr;

    logic    result_valid_reg;
    result_t result_reg;

    assign item_stall = !seq_idle;
    assign seq_start  = item_valid && seq_idle;
    assign seq_take   = seq_done && (!result_valid_reg || !result_stall);

    rrts_slot_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr       (wr)
    );

    rrts_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (seq_start),
        .item     (item),
        .idle     (seq_idle),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr       (wr),
        .done     (seq_done),
        .res      (seq_res),
        .take     (seq_take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (seq_take)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_take)
        begin
            result_reg <= seq_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "accepted beat did not hold off the next one")
    `ASSERT_IMPLY(a_no_free_id_zero, result_valid && result.status == STAT_NO_FREE, result.thread_id == '0, "no-free result carries a nonzero slot")
    `ASSERT_IMPLY(a_main_exit_slot, result_valid && result.status == STAT_MAIN_BUSY, result.running_slot == '0, "main-exit status while main is not current")
    `ASSERT_IMPLY(a_blocked_is_caller, result_valid && result.status == STAT_BLOCKED, result.thread_id == result.running_slot, "blocked caller is not the current slot")

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    import rrts_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 232;
    localparam int MAX_PRINTS   = 100;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int cycles = 0;

    result_t pending_results[$];

    logic [PHASE_W-1:0] sl_phase   [THREAD_SLOTS];
    logic               sl_exited  [THREAD_SLOTS];
    logic               sl_blocked [THREAD_SLOTS];
    logic               sl_jvalid  [THREAD_SLOTS];
    logic [ID_W-1:0]    sl_joiner  [THREAD_SLOTS];
    logic [ID_W-1:0]    run_slot;

    round_robin_thread_scheduler_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    function automatic void clear_table();
        for (int i = 0; i < THREAD_SLOTS; i++)
        begin
            sl_phase[i]   = PH_FREE;
            sl_exited[i]  = 1'b0;
            sl_blocked[i] = 1'b0;
            sl_jvalid[i]  = 1'b0;
            sl_joiner[i]  = '0;
        end
        sl_phase[0] = PH_RUNNING;
        run_slot    = '0;
    endfunction

    function automatic result_t schedule_step(input item_t it);
        result_t r;
        int      idx;
        int      scan;
        int      steps;
        int      old;
        int      tgt;
        bit      found;
        r.thread_id    = run_slot;
        r.status       = STAT_DONE;
        r.running_slot = '0;
        case (it.action)
            ACT_CREATE:
            begin
                found = 1'b0;
                idx   = 0;
                for (int i = 0; i < THREAD_SLOTS; i++)
                begin
                    if (!found && !sl_exited[i] && sl_phase[i] == PH_FREE)
                    begin
                        found = 1'b1;
                        idx   = i;
                    end
                end
                if (found)
                begin
                    sl_phase[idx]   = PH_READY;
                    sl_blocked[idx] = 1'b0;
                    sl_exited[idx]  = 1'b0;
                    r.thread_id     = ID_W'(idx);
                end
                else
                begin
                    r.thread_id = '0;
                    r.status    = STAT_NO_FREE;
                end
            end
            ACT_TICK:
            begin
                old   = int'(run_slot);
                scan  = old;
                steps = 0;
                while (!(sl_phase[scan] == PH_READY && !sl_blocked[scan])
                       && steps < THREAD_SLOTS)
                begin
                    scan = (scan + 1) % THREAD_SLOTS;
                    steps++;
                end
                if (sl_phase[old] == PH_RUNNING)
                    sl_phase[old] = PH_READY;
                sl_phase[scan] = PH_RUNNING;
                run_slot       = ID_W'(scan);
                r.thread_id    = ID_W'(scan);
            end
            ACT_JOIN:
            begin
                tgt = int'(it.target_slot);
                if (tgt < THREAD_SLOTS && !sl_exited[tgt])
                begin
                    sl_joiner[tgt]       = run_slot;
                    sl_jvalid[tgt]       = 1'b1;
                    sl_blocked[run_slot] = 1'b1;
                    r.status             = STAT_BLOCKED;
                end
            end
            default:
            begin
                if (sl_jvalid[run_slot])
                    sl_blocked[sl_joiner[run_slot]] = 1'b0;
                if (run_slot == '0)
                begin
                    for (int i = 1; i < THREAD_SLOTS; i++)
                    begin
                        if (sl_phase[i] == PH_READY)
                            r.status = STAT_MAIN_BUSY;
                    end
                end
                else
                begin
                    sl_phase[run_slot]  = PH_FREE;
                    sl_exited[run_slot] = 1'b1;
                end
            end
        endcase
        r.running_slot = run_slot;
        return r;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("beat with nothing pending: id %0d st %0d run %0d",
                                          result.thread_id, result.status,
                                          result.running_slot));
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (result.thread_id !== want.thread_id)
                    report_mismatch($sformatf("thread_id %0d, want %0d",
                                              result.thread_id, want.thread_id));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              result.status, want.status));
                if (result.running_slot !== want.running_slot)
                    report_mismatch($sformatf("running_slot %0d, want %0d",
                                              result.running_slot, want.running_slot));
            end
        end
    end

    task automatic send_item(input item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        pending_results.push_back(schedule_step(it));
        sent++;
    endtask

    task automatic send_op(input logic [ACTION_W-1:0] act, input int tgt);
        item_t it;
        it.action      = act;
        it.target_slot = ID_W'(tgt);
        send_item(it);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            it.action = ACT_CREATE;
        else if (pick < 70)
            it.action = ACT_TICK;
        else if (pick < 94)
            it.action = ACT_JOIN;
        else
            it.action = ACT_EXIT;
        it.target_slot = ID_W'($urandom_range(0, THREAD_SLOTS - 1));
        return it;
    endfunction

    task automatic run_random(input int count, input int sender_idle, input int recv_stall);
        idle_pct  = sender_idle;
        stall_pct = recv_stall;
        for (int n = 0; n < count; n++)
            send_item(random_item());
        hold_until_drained();
    endtask

    task automatic test_edge_cases();
        idle_pct  = 0;
        stall_pct = 0;
        send_op(ACT_TICK, 0);
        send_op(ACT_EXIT, 0);
        send_op(ACT_JOIN, 15);
        send_op(ACT_CREATE, 0);
        send_op(ACT_EXIT, 0);
        send_op(ACT_TICK, 0);
        send_op(ACT_EXIT, 0);
        send_op(ACT_JOIN, 1);
        send_op(ACT_TICK, 0);
        send_op(ACT_CREATE, 0);
        send_op(ACT_TICK, 0);
        send_op(ACT_JOIN, 2);
        send_op(ACT_EXIT, 0);
        for (int n = 0; n < 14; n++)
            send_op(ACT_CREATE, 0);
        hold_until_drained();
    endtask

    task automatic test_random_steady();
        run_random(PHASE_ITEMS, 0, 0);
    endtask

    task automatic test_random_sparse_sender();
        run_random(PHASE_ITEMS, 88, 0);
    endtask

    task automatic test_random_slow_receiver();
        run_random(PHASE_ITEMS, 0, 88);
    endtask

    task automatic test_random_both_throttled();
        run_random(PHASE_ITEMS, 15, 15);
    endtask

    initial
    begin
        clear_table();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_edge_cases();
        test_random_steady();
        test_random_sparse_sender();
        test_random_slow_receiver();
        test_random_both_throttled();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("tb: %0d actions sent, %0d result beats checked, %0d mismatches",
                 sent, checked, errors);
        $display("tb: covered create/tick/join/exit under steady, sparse, stalled and mixed pacing");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_slot_table.sv
rtl/core/rrts_seq.sv
rtl/core/round_robin_thread_scheduler_core.sv
tb/sv/tb_top.sv
